@@ src/sdsf_pkg.sv @@
// Package for the signed decimal seven-segment formatter.
// Holds widths, segment codes, the reciprocal used for divide-by-ten and
// the digit bundle type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdsf_pkg;

	localparam int VALUE_W = 11;
	localparam int MAG_W   = 11;
	localparam int SEG_W   = 8;
	localparam int DIGIT_W = 4;

	// Active-low patterns
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h7F;

	// floor(x * 205 / 2048) == floor(x / 10) for x below 1029
	localparam int RECIP_10    = 205;
	localparam int RECIP_SHIFT = 11;

	typedef struct packed {
		logic               neg;
		logic [DIGIT_W-1:0] d3;
		logic [DIGIT_W-1:0] d2;
		logic [DIGIT_W-1:0] d1;
		logic [DIGIT_W-1:0] d0;
	} digits_t;

	function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h81;
			4'd1: s = 8'hF3;
			4'd2: s = 8'h49;
			4'd3: s = 8'h61;
			4'd4: s = 8'h33;
			4'd5: s = 8'h25;
			4'd6: s = 8'h05;
			4'd7: s = 8'hF1;
			4'd8: s = 8'h01;
			4'd9: s = 8'h21;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	// 10^n - 1, evaluated at elaboration
	function automatic logic [31:0] max_mag(input int n);
		logic [31:0] m;
		m = 32'd1;
		for (int k = 0; k < n; k++) begin
			m = m * 32'd10;
		end
		return m - 32'd1;
	endfunction

endpackage

`default_nettype wire

@@ src/sdsf_mag.sv @@
// First pipeline stage: sign and saturated magnitude of the input value.
// Depends on sdsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdsf_mag #(
	parameter int NUM_DIGITS = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [sdsf_pkg::VALUE_W-1:0] value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     neg,
	output logic [sdsf_pkg::MAG_W-1:0]               mag
);
	import sdsf_pkg::*;

	localparam logic [31:0] LIM = max_mag(NUM_DIGITS);

	logic               valid_s1;
	logic               neg_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic [MAG_W-1:0]   abs_val;
	logic [MAG_W-1:0]   mag_c;

	assign in_stall = valid_s1 && out_stall;

	always_comb begin
		abs_val = value[VALUE_W-1] ? MAG_W'(-value) : MAG_W'(value);
		if ({{(32-MAG_W){1'b0}}, abs_val} > LIM) begin
			mag_c = LIM[MAG_W-1:0];
		end else begin
			mag_c = abs_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			neg_s1 <= value[VALUE_W-1];
			mag_s1 <= mag_c;
		end
	end

	assign out_valid = valid_s1;
	assign neg       = neg_s1;
	assign mag       = mag_s1;

endmodule

`default_nettype wire

@@ src/sdsf_bcd.sv @@
// Stages two to four split the magnitude into decimal digits: stages
// two and three divide by ten, then a fix-up. Depends on sdsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdsf_bcd (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       neg,
	input  wire logic [sdsf_pkg::MAG_W-1:0] mag,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output sdsf_pkg::digits_t               digits
);
	import sdsf_pkg::*;

	localparam int P1_W = MAG_W + 8;
	localparam int Q1_W = 7;
	localparam int P2_W = Q1_W + 8;
	localparam int Q2_W = 4;

	logic valid_s2, valid_s3, valid_s4;
	logic stall_s2, stall_s3, stall_s4;

	logic               neg_s2, neg_s3;
	logic [Q1_W-1:0]    q10_s2;
	logic [DIGIT_W-1:0] d0_s2, d0_s3;
	logic [Q2_W-1:0]    q100_s3;
	logic [DIGIT_W-1:0] d1_s3;
	digits_t            dig_s4;

	logic [P1_W-1:0]    prod1;
	logic [Q1_W-1:0]    q10;
	logic [DIGIT_W-1:0] d0;
	logic [P2_W-1:0]    prod2;
	logic [Q2_W-1:0]    q100;
	logic [DIGIT_W-1:0] d1;
	digits_t            dig_n;

	assign stall_s4 = valid_s4 && out_stall;
	assign stall_s3 = valid_s3 && stall_s4;
	assign stall_s2 = valid_s2 && stall_s3;
	assign in_stall = stall_s2;

	always_comb begin
		prod1 = P1_W'(mag) * P1_W'(RECIP_10);
		q10   = prod1[RECIP_SHIFT +: Q1_W];
		d0    = DIGIT_W'(mag - MAG_W'(q10) * MAG_W'(10));

		prod2 = P2_W'(q10_s2) * P2_W'(RECIP_10);
		q100  = prod2[RECIP_SHIFT +: Q2_W];
		d1    = DIGIT_W'(q10_s2 - Q1_W'(q100) * Q1_W'(10));

		dig_n.neg = neg_s3;
		dig_n.d1  = d1_s3;
		dig_n.d0  = d0_s3;
		if (q100_s3 >= Q2_W'(10)) begin
			dig_n.d3 = DIGIT_W'(1);
			dig_n.d2 = DIGIT_W'(q100_s3 - Q2_W'(10));
		end else begin
			dig_n.d3 = '0;
			dig_n.d2 = DIGIT_W'(q100_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (!stall_s2) begin
				valid_s2 <= in_valid;
			end
			if (!stall_s3) begin
				valid_s3 <= valid_s2;
			end
			if (!stall_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !stall_s2) begin
			neg_s2 <= neg;
			q10_s2 <= q10;
			d0_s2  <= d0;
		end
		if (valid_s2 && !stall_s3) begin
			neg_s3  <= neg_s2;
			q100_s3 <= q100;
			d1_s3   <= d1;
			d0_s3   <= d0_s2;
		end
		if (valid_s3 && !stall_s4) begin
			dig_s4 <= dig_n;
		end
	end

	assign out_valid = valid_s4;
	assign digits    = dig_s4;

endmodule

`default_nettype wire

@@ src/sdsf_ser.sv @@
// Output serializer: encodes sign and digits with leading-zero blanking and
// sends them one byte per transaction, flagging the final one. Depends on sdsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdsf_ser #(
	parameter int NUM_DIGITS = 3
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire sdsf_pkg::digits_t        digits,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [sdsf_pkg::SEG_W-1:0]    segments,
	output logic                          last
);
	import sdsf_pkg::*;

	localparam int POS_W = $clog2(NUM_DIGITS + 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS);

	logic                 valid_q;
	logic [POS_W-1:0]     pos_q;
	logic [SEG_W-1:0]     bytes_q [0:NUM_DIGITS];
	logic [SEG_W-1:0]     bytes_n [0:NUM_DIGITS];
	logic                 at_last;
	logic                 seen;
	logic [DIGIT_W-1:0]   dig;

	assign at_last  = (pos_q == LAST_POS);
	assign in_stall = valid_q && !(at_last && !out_stall);

	// Leftmost byte is the sign; digit positions follow, most significant first
	always_comb begin
		seen = 1'b0;
		dig  = '0;
		bytes_n[0] = digits.neg ? SEG_MINUS : SEG_BLANK;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			case (NUM_DIGITS - 1 - k)
				0: dig = digits.d0;
				1: dig = digits.d1;
				2: dig = digits.d2;
				3: dig = digits.d3;
				default: dig = '0;
			endcase
			seen = seen || (dig != '0);
			if (!seen && (k != NUM_DIGITS - 1)) begin
				bytes_n[k+1] = SEG_BLANK;
			end else begin
				bytes_n[k+1] = seg_encode(dig);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
			pos_q   <= '0;
		end else if (!out_stall) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			for (int k = 0; k <= NUM_DIGITS; k++) begin
				bytes_q[k] <= bytes_n[k];
			end
		end
	end

	assign out_valid = valid_q;
	assign segments  = bytes_q[pos_q];
	assign last      = valid_q && at_last;

endmodule

`default_nettype wire

@@ src/signed_decimal_seven_segment_formatter_core.sv @@
// Top level of the signed decimal seven-segment formatter.
// Depends on sdsf_pkg, sdsf_mag, sdsf_bcd and sdsf_ser.
`timescale 1ns / 1ps
`default_nettype none

// Takes a signed 11-bit value and emits NUM_DIGITS + 1 active-low segment
// bytes in display order: a sign byte (minus or blank) and then the decimal
// digits, most significant first, with leading zeros blanked and the units
// digit always shown. The final byte of each value carries last. Magnitudes
// beyond 10^NUM_DIGITS - 1 saturate to that maximum. Four register stages
// (magnitude, two divide-by-ten stages, digit fix-up) take one value per
// cycle when not stalled; the first byte of a value is then presented from
// the serializer register. The output serializer sends one byte per cycle
// when the output is not stalled, and the next value is accepted while the
// current one is still being sent.
module signed_decimal_seven_segment_formatter_core #(
	parameter int NUM_DIGITS = 3
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [sdsf_pkg::VALUE_W-1:0] value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [sdsf_pkg::SEG_W-1:0]               segments,
	output logic                                     last
);
	import sdsf_pkg::*;

	logic             mag_valid, mag_stall, mag_neg;
	logic [MAG_W-1:0] mag_val;
	logic             dig_valid, dig_stall;
	digits_t          dig;
	logic             first_q;

	sdsf_mag #(.NUM_DIGITS(NUM_DIGITS)) u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (mag_valid),
		.out_stall (mag_stall),
		.neg       (mag_neg),
		.mag       (mag_val)
	);

	sdsf_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mag_valid),
		.in_stall  (mag_stall),
		.neg       (mag_neg),
		.mag       (mag_val),
		.out_valid (dig_valid),
		.out_stall (dig_stall),
		.digits    (dig)
	);

	sdsf_ser #(.NUM_DIGITS(NUM_DIGITS)) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dig_valid),
		.in_stall  (dig_stall),
		.digits    (dig),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.segments  (segments),
		.last      (last)
	);

	// Track whether the next output byte opens a new value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			first_q <= last;
		end
	end

	// A value's bytes are sent without gaps once started
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> out_valid)
		else $error("output gap inside a transaction group");

	// Input back-pressure only ever originates at a busy output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output pending");

	// The opening byte of each value is the sign position
	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_q) |-> (segments == SEG_BLANK || segments == SEG_MINUS))
		else $error("first byte is not a sign position");

	// The sign position never carries last
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_q) |-> !last)
		else $error("last flagged on the sign byte");

endmodule

`default_nettype wire
